@@ hdl/fsbu_pkg.sv @@
package fsbu_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 16;
	localparam int unsigned BitsPerByteIn = 7;
	localparam int unsigned PendW  = BitsPerByteIn;
	localparam int unsigned PendCntW = 3;

	localparam logic [ByteW-1:0] StartMarkerRst = 8'd0;
	localparam logic [ByteW-1:0] EndMarkerRst   = 8'd2;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	typedef enum logic {
		REG_START_MARKER = 1'b0,
		REG_END_MARKER   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] in_byte;
		logic             buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0]  out_byte;
		logic [1:0]        kind;
		logic [CountW-1:0] byte_count;
		logic              last;
	} out_item_t;

endpackage

@@ hdl/framed_seven_bit_unpacker_core.sv @@
// A result is registered and appears on the output in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; a request that
// gives two results (a decoded byte followed by an abort) holds the input while the
// second result drains. The two-entry result register sets this figure.
// Reset (arst_n low, asynchronous): hunting for a start byte, no held bits, count zero,
// result register empty, markers back to start 0 and end 2.
module framed_seven_bit_unpacker_core
	import fsbu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  reg_idx_t  cfg_index,
	input  logic [ByteW-1:0] cfg_data
);

	logic [ByteW-1:0]    start_marker_q;
	logic [ByteW-1:0]    end_marker_q;
	logic                in_frame_q;
	logic [PendW-1:0]    bit_pending_q;
	logic [PendCntW-1:0] pend_cnt_q;
	logic [CountW-1:0]   frame_bytes_q;
	out_item_t           res_q [2];
	logic [1:0]          res_cnt_q;

	logic pop;
	logic accept;

	// Next-state and result logic for one request.
	logic                in_frame_d;
	logic [PendW-1:0]    bit_pending_d;
	logic [PendCntW-1:0] pend_cnt_d;
	logic [CountW-1:0]   frame_bytes_d;
	out_item_t           r0;
	out_item_t           r1;
	logic [1:0]          n_res;
	logic [2*PendW-1:0]  acc;
	logic [PendCntW-1:0] rem;
	logic [2*PendW-1:0]  shifted;
	logic [PendW-1:0]    rem_mask;

	assign cfg_ready = 1'b1;
	assign out_valid = (res_cnt_q != 2'd0);
	assign out_data  = res_q[0];
	assign pop       = out_valid && !out_stall;
	assign in_stall  = !((res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && pop));
	assign accept    = in_valid && !in_stall;

	assign acc      = {bit_pending_q, in_data.in_byte[ByteW-1:1]};
	assign rem      = pend_cnt_q - PendCntW'(1);
	assign shifted  = acc >> rem;
	assign rem_mask = PendW'((8'd1 << rem) - 8'd1);

	always_comb begin
		in_frame_d    = in_frame_q;
		bit_pending_d = bit_pending_q;
		pend_cnt_d    = pend_cnt_q;
		frame_bytes_d = frame_bytes_q;
		r0            = '0;
		r1            = '0;
		n_res         = 2'd0;

		if (!in_frame_q) begin
			if (in_data.in_byte == start_marker_q) begin
				in_frame_d    = 1'b1;
				bit_pending_d = '0;
				pend_cnt_d    = '0;
				frame_bytes_d = '0;
			end
		end else if (in_data.in_byte == end_marker_q) begin
			r0.kind       = KIND_CLOSE;
			r0.byte_count = frame_bytes_q;
			n_res         = 2'd1;
			in_frame_d    = 1'b0;
			bit_pending_d = '0;
			pend_cnt_d    = '0;
			frame_bytes_d = '0;
		end else if (pend_cnt_q != '0) begin
			// Held bits plus seven new ones reach a full byte.
			if (frame_bytes_q != {CountW{1'b1}}) begin
				frame_bytes_d = frame_bytes_q + CountW'(1);
			end
			r0.out_byte   = shifted[ByteW-1:0];
			r0.kind       = KIND_DATA;
			r0.byte_count = frame_bytes_d;
			n_res         = 2'd1;
			bit_pending_d = acc[PendW-1:0] & rem_mask;
			pend_cnt_d    = rem;
		end else begin
			bit_pending_d = acc[PendW-1:0];
			pend_cnt_d    = PendCntW'(BitsPerByteIn);
		end

		if (in_data.buffer_end && in_frame_d) begin
			if (n_res == 2'd0) begin
				r0.kind       = KIND_ABORT;
				r0.byte_count = frame_bytes_d;
			end else begin
				r1.kind       = KIND_ABORT;
				r1.byte_count = frame_bytes_d;
			end
			n_res         = n_res + 2'd1;
			in_frame_d    = 1'b0;
			bit_pending_d = '0;
			pend_cnt_d    = '0;
			frame_bytes_d = '0;
		end

		if (n_res == 2'd2) begin
			r1.last = 1'b1;
		end else begin
			r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= StartMarkerRst;
			end_marker_q   <= EndMarkerRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			bit_pending_q <= '0;
			pend_cnt_q    <= '0;
			frame_bytes_q <= '0;
		end else if (accept) begin
			in_frame_q    <= in_frame_d;
			bit_pending_q <= bit_pending_d;
			pend_cnt_q    <= pend_cnt_d;
			frame_bytes_q <= frame_bytes_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else if (accept) begin
			res_cnt_q <= n_res;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	// An accept always finds the result register drained, so it simply reloads both slots.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q[0] <= r0;
			res_q[1] <= r1;
		end else if (pop) begin
			res_q[0] <= res_q[1];
		end
	end

	a_res_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result register holds more than two entries");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (pend_cnt_q == '0) && (frame_bytes_q == '0))
		else $error("frame state left over while hunting");

	a_buffer_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.buffer_end |=> !in_frame_q)
		else $error("frame still open after buffer end");

	a_abort_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == KIND_ABORT) |-> out_data.last)
		else $error("abort result not marked last");

endmodule

@@ sim/unpack_checker.sv @@
module unpack_checker
	import fsbu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_item_t        out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  reg_idx_t         cfg_index,
	input  logic [ByteW-1:0] cfg_data,
	output int               fail_count,
	output int               queued,
	output int               results_seen,
	output int               closes_seen,
	output int               aborts_seen
);

	logic [ByteW-1:0]    start_mark;
	logic [ByteW-1:0]    end_mark;
	logic                framing;
	logic [PendW-1:0]    held;
	logic [PendCntW-1:0] held_n;
	logic [CountW-1:0]   nbytes;

	out_item_t unpacked_q[$];
	out_item_t want;
	int        miss_n;
	int        got_n;
	int        close_n;
	int        abort_n;

	task automatic flag_miss(input string why);
		miss_n++;
		if (miss_n <= 20) begin
			$display("MISMATCH @%0t: %s", $time, why);
		end
	endtask

	function automatic void queue_result(input logic [ByteW-1:0] b, input kind_t k,
			input logic [CountW-1:0] c);
		out_item_t r;
		r.out_byte   = b;
		r.kind       = k;
		r.byte_count = c;
		r.last       = 1'b0;
		unpacked_q.push_back(r);
	endfunction

	function automatic void drop_frame();
		framing = 1'b0;
		held    = '0;
		held_n  = '0;
		nbytes  = '0;
	endfunction

	// Seven payload bits per frame byte are shifted into the held bits; a full
	// byte is peeled off the top whenever at least eight bits are available.
	function automatic void unpack_byte(input in_item_t req);
		logic [13:0]      acc;
		logic [13:0]      shifted;
		logic [3:0]       total;
		logic [2:0]       rem;
		int               first;
		first = unpacked_q.size();
		if (!framing) begin
			if (req.in_byte == start_mark) begin
				drop_frame();
				framing = 1'b1;
			end
		end else if (req.in_byte == end_mark) begin
			queue_result('0, KIND_CLOSE, nbytes);
			drop_frame();
		end else begin
			acc   = {held, req.in_byte[7:1]};
			total = {1'b0, held_n} + 4'd7;
			if (total >= 4'd8) begin
				rem     = 3'(total - 4'd8);
				shifted = acc >> rem;
				if (nbytes != '1) begin
					nbytes = nbytes + CountW'(1);
				end
				queue_result(shifted[7:0], KIND_DATA, nbytes);
				held   = 7'(acc & ((14'd1 << rem) - 14'd1));
				held_n = rem;
			end else begin
				held   = acc[6:0];
				held_n = total[2:0];
			end
		end
		if (req.buffer_end && framing) begin
			queue_result('0, KIND_ABORT, nbytes);
			drop_frame();
		end
		if (unpacked_q.size() > first) begin
			unpacked_q[$].last = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mark = StartMarkerRst;
			end_mark   = EndMarkerRst;
			drop_frame();
			unpacked_q.delete();
			miss_n  = 0;
			got_n   = 0;
			close_n = 0;
			abort_n = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_n++;
				if (unpacked_q.size() == 0) begin
					flag_miss($sformatf("unexpected result byte %02h kind %0d count %0d last %0b",
						out_data.out_byte, out_data.kind, out_data.byte_count, out_data.last));
				end else begin
					want = unpacked_q.pop_front();
					if (out_data.out_byte !== want.out_byte || out_data.kind !== want.kind ||
							out_data.byte_count !== want.byte_count ||
							out_data.last !== want.last) begin
						flag_miss($sformatf({"got byte %02h kind %0d count %0d last %0b, ",
							"want byte %02h kind %0d count %0d last %0b"},
							out_data.out_byte, out_data.kind, out_data.byte_count,
							out_data.last, want.out_byte, want.kind, want.byte_count,
							want.last));
					end
					if (want.kind == KIND_CLOSE) begin
						close_n++;
					end else if (want.kind == KIND_ABORT) begin
						abort_n++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_START_MARKER) begin
					start_mark = cfg_data;
				end else begin
					end_mark = cfg_data;
				end
			end
			if (in_valid && !in_stall) begin
				unpack_byte(in_data);
			end
		end
		fail_count   <= miss_n;
		queued       <= unpacked_q.size();
		results_seen <= got_n;
		closes_seen  <= close_n;
		aborts_seen  <= abort_n;
	end

endmodule

@@ sim/framed_seven_bit_unpacker_core_tb.sv @@
module framed_seven_bit_unpacker_core_tb;
	import fsbu_pkg::*;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	reg_idx_t         cfg_index = REG_START_MARKER;
	logic [ByteW-1:0] cfg_data  = '0;

	int fails;
	int queued;
	int results_seen;
	int closes_seen;
	int aborts_seen;

	logic [ByteW-1:0] start_mark = StartMarkerRst;
	logic [ByteW-1:0] end_mark   = EndMarkerRst;
	bit               src_gaps   = 1'b1;
	bit               sink_gaps  = 1'b1;
	bit               hold_req   = 1'b0;
	int               reqs_sent  = 0;
	int               settings   = 0;

	// Directed bytes {in_byte, buffer_end} under the reset markers (start 00, end 02).
	localparam logic [8:0] Script [20] = '{
		{8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0}, {8'hFE, 1'b0},
		{8'h80, 1'b0}, {8'h7F, 1'b0}, {8'hAA, 1'b0}, {8'h55, 1'b0}, {8'h02, 1'b0},
		{8'h00, 1'b0}, {8'h02, 1'b0}, {8'h37, 1'b1}, {8'h00, 1'b1}, {8'h00, 1'b0},
		{8'hFF, 1'b0}, {8'hFF, 1'b1}, {8'h00, 1'b0}, {8'h02, 1'b1}, {8'h02, 1'b0}
	};

	framed_seven_bit_unpacker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	unpack_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fails),
		.queued       (queued),
		.results_seen (results_seen),
		.closes_seen  (closes_seen),
		.aborts_seen  (aborts_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off that backs up the block.
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Offers one request and returns at the edge where it is taken; valid stays
	// high so that back-to-back requests need no extra assignment.
	task automatic push_byte(input logic [ByteW-1:0] b, input logic be);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{in_byte: b, buffer_end: be};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		reqs_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (queued != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_markers(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e);
		cfg_valid <= 1'b1;
		cfg_index <= REG_START_MARKER;
		cfg_data  <= s;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_END_MARKER;
		cfg_data  <= e;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		start_mark = s;
		end_mark   = e;
		settings++;
	endtask

	// Mostly well-formed frames with random payload; some are cut short by a
	// buffer end, and a few noise bytes sit between frames.
	task automatic run_frames(input int quota);
		int               done;
		int               len;
		int               cut;
		logic [ByteW-1:0] b;
		done = 0;
		while (done < quota) begin
			repeat ($urandom_range(0, 2)) begin
				do b = 8'($urandom); while (b == start_mark);
				push_byte(b, $urandom_range(0, 7) == 0);
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
			push_byte(start_mark, cut == 0);
			done++;
			if (cut != 0) begin
				for (int k = 1; k <= len; k++) begin
					if (start_mark != end_mark && $urandom_range(0, 11) == 0) begin
						b = start_mark;
					end else begin
						do b = 8'($urandom); while (b == end_mark);
					end
					push_byte(b, k == cut);
					done++;
					if (k == cut) break;
				end
				if (cut < 0) begin
					push_byte(end_mark, $urandom_range(0, 3) == 0);
					done++;
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (Script[i]) begin
			push_byte(Script[i][8:1], Script[i][0]);
		end
		settle();

		// With equal markers the same byte opens and then closes the frame.
		program_markers(8'hA5, 8'hA5);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'hA5, 1'b0);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: program_markers(8'hFF, 8'h00);
				1: program_markers(8'h00, 8'hFF);
				2: program_markers(8'h7E, 8'h7E);
				default: program_markers(8'($urandom), 8'($urandom));
			endcase
			sink_gaps = (ph != 3);
			if (ph == 1) begin
				hold_req = 1'b1;
			end
			run_frames(225);
			settle();
		end

		// The last stretch runs with no idling on either side.
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		program_markers(StartMarkerRst, EndMarkerRst);
		run_frames(225);
		settle();
		repeat (8) @(posedge clk);

		$display("Sent %0d requests under %0d marker settings, with idle bursts and a long hold.",
			reqs_sent, settings);
		$display("Checked %0d results: %0d frames closed, %0d aborted, %0d mismatches.",
			results_seen, closes_seen, aborts_seen, fails);
		if (fails == 0 && queued == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
